// File: rtl/bdeq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded double-ended queue.
// No dependencies.
package bdeq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_REM_FRONT = 3'd2,
    REQ_REM_BACK  = 3'd3,
    REQ_CLEAR     = 3'd4,
    REQ_DUMP      = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_ELEM  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_e;

endpackage

// File: rtl/bounded_double_ended_queue.sv
`timescale 1ns / 1ps
// Bounded double-ended queue on a ring buffer (head pointer plus count).
// Insert, remove, clear: result registered in the cycle after the input transfer;
// one request per cycle while the output drains.
// Dump: the first element passes through the registered read of the storage RAM, then the output
// register; then one per cycle while the output drains; input is held off until the last one.
// Reset clears head, count, the dump state and the output valid flag; the storage is not cleared.
// Depends on bdeq_pkg and bdeq_ram.
module bounded_double_ended_queue
  import bdeq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               req_type_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] element_o,
  output logic [CNT_W-1:0]         occupancy_o,
  output logic                     last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0]      DEPTH_S  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  state_e               state_q, state_d;
  logic [AW-1:0]        head_q, head_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [AW-1:0]        ptr_q, ptr_d;

  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [DATA_W-1:0]    element_q, element_d;
  logic [CNT_W-1:0]     occ_q, occ_d;
  logic                 last_q, last_d;

  logic                 out_free;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [AW:0]          back_sum;
  logic [AW-1:0]        back_idx;
  logic [AW-1:0]        head_dec;
  logic [AW-1:0]        head_inc;
  logic [AW-1:0]        ptr_inc;
  logic                 dump_last;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [DATA_W-1:0]    rdata;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == DEPTH_C);
  assign empty      = (count_q == '0);

  // Ring arithmetic: every sum stays below twice the depth.
  assign back_sum  = {1'b0, head_q} + count_q[AW:0];
  assign back_idx  = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : back_sum[AW-1:0];
  assign head_dec  = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
  assign head_inc  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign ptr_inc   = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
  assign dump_last = ((idx_q + 1'b1) == count_q);

  // During a dump, prefetch the next element when the current one moves to the output; else read at the head.
  always_comb begin
    if (state_q == S_DUMP) begin
      raddr = out_free ? ptr_inc : ptr_q;
    end else begin
      raddr = head_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    element_d   = element_q;
    occ_d       = occ_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = back_idx;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d  = STS_DONE;
          element_d = '0;
          last_d    = 1'b1;
          case (req_e'(req_type_i))
            REQ_INS_FRONT: begin
              if (full) begin
                status_d = STS_FULL;
              end else begin
                head_d  = head_dec;
                count_d = count_q + 1'b1;
                we      = 1'b1;
                waddr   = head_dec;
              end
            end
            REQ_INS_BACK: begin
              if (full) begin
                status_d = STS_FULL;
              end else begin
                count_d = count_q + 1'b1;
                we      = 1'b1;
              end
            end
            REQ_REM_FRONT: begin
              if (empty) begin
                status_d = STS_EMPTY;
              end else begin
                head_d  = head_inc;
                count_d = count_q - 1'b1;
              end
            end
            REQ_REM_BACK: begin
              if (empty) begin
                status_d = STS_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            REQ_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            REQ_DUMP: begin
              if (empty) begin
                status_d = STS_EMPTY;
              end else begin
                state_d = S_DUMP;
                idx_d   = '0;
                ptr_d   = head_q;
              end
            end
            default: begin
              // Undefined request: report current occupancy and do nothing.
            end
          endcase
          occ_d       = count_d;
          out_valid_d = (state_d == S_IDLE);
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = STS_ELEM;
          element_d   = rdata;
          occ_d       = count_q;
          last_d      = dump_last;
          idx_d       = idx_q + 1'b1;
          ptr_d       = ptr_inc;
          if (dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    element_q <= element_d;
    occ_q     <= occ_d;
    last_q    <= last_d;
  end

  bdeq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(value_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign occupancy_o = occ_q;
  assign last_o      = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("count exceeds depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LAST_IDX)
    else $error("head outside ring");

  a_dump_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> (idx_q < count_q))
    else $error("dump index past count");

  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP && out_free && dump_last) |=> (state_q == S_IDLE && last_o))
    else $error("dump did not end on last element");

endmodule

// File: rtl/bdeq_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bdeq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
